// ----- hdl/lpd_pkg.sv -----
`default_nettype none

package lpd_pkg;

  // item geometry
  localparam int LANES         = 4;
  localparam int COORD_BITS    = 16;
  localparam int SUM_BITS      = 48;
  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int PROD_BITS     = SUM_BITS + DIFF_BITS;
  localparam int LANE_CNT_BITS = $clog2(LANES + 1);
  localparam int GRP_BITS      = SUM_BITS + $clog2(LANES);
  localparam int RUN_BITS      = GRP_BITS + 1;

  // exponent
  localparam int POW_BITS = 3;
  localparam int POW_MAX  = 4;
  localparam int MUL_BITS = 2;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POWER = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT = 1'd1;

  // control from the sequencer to the merge stage
  typedef struct packed {
    logic capture;
    logic load;
    logic clear;
  } merge_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/lpd_if.sv -----
`default_nettype none

interface lpd_in_if;
  import lpd_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_a0;
  logic signed [COORD_BITS-1:0] coord_a1;
  logic signed [COORD_BITS-1:0] coord_a2;
  logic signed [COORD_BITS-1:0] coord_a3;
  logic signed [COORD_BITS-1:0] coord_b0;
  logic signed [COORD_BITS-1:0] coord_b1;
  logic signed [COORD_BITS-1:0] coord_b2;
  logic signed [COORD_BITS-1:0] coord_b3;
  logic [2:0]                   lanes_valid;
  logic                         last_group;

  modport source (
    output valid, coord_a0, coord_a1, coord_a2, coord_a3,
           coord_b0, coord_b1, coord_b2, coord_b3, lanes_valid, last_group,
    input  ready
  );

  modport sink (
    input  valid, coord_a0, coord_a1, coord_a2, coord_a3,
           coord_b0, coord_b1, coord_b2, coord_b3, lanes_valid, last_group,
    output ready
  );
endinterface

interface lpd_out_if;
  import lpd_pkg::*;

  logic                valid;
  logic                ready;
  logic [SUM_BITS-1:0] distance_sum;
  logic                abandoned;

  modport source (
    output valid, distance_sum, abandoned,
    input  ready
  );

  modport sink (
    input  valid, distance_sum, abandoned,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/lp_distance_early_abandon.sv -----
`default_nettype none

// channel   dir  handshake     payload
// in_i      in   valid/ready   coord_a0..3, coord_b0..3, lanes_valid, last_group
// out_o     out  valid/ready   distance_sum, abandoned
// cfg       in   cfg_we_i      cfg_idx_i (0 power, 1 abandon_limit), cfg_data_i
//
// a group is accepted, then the lane multipliers run p - 1 saturating multiplies for
// exponent p (0 counts as 1, above 4 as 4), then the merge adds the group into the sum.
// items met while discarding are accepted and dropped. one group in flight at a time.
// reset clears the running sum, the discard flag, power to 1 and the limit to 0.
// a result waits in the output register; a merge that emits a result stalls if it is still full.

module lp_distance_early_abandon (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [lpd_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [lpd_pkg::SUM_BITS-1:0]        cfg_data_i,
  lpd_in_if.sink                                   in_i,
  lpd_out_if.source                                out_o
);
  import lpd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LANE = 2'd1;
  localparam logic [1:0] S_SUM  = 2'd2;

  logic [1:0]               state_q;
  logic [1:0]               state_d;
  logic [POW_BITS-1:0]      power_q;
  logic [SUM_BITS-1:0]      limit_q;
  logic                     discarding_q;
  logic                     discarding_d;
  logic [LANE_CNT_BITS-1:0] lanes_q;
  logic [LANE_CNT_BITS-1:0] lanes_clamped;
  logic                     last_q;
  logic [MUL_BITS-1:0]      mul_cnt;
  logic                     accept;
  logic                     start;
  logic                     slot_free;
  logic                     emit;
  logic                     out_load;
  merge_ctrl_t              merge_ctrl;

  logic signed [LANES-1:0][COORD_BITS-1:0] coord_a;
  logic signed [LANES-1:0][COORD_BITS-1:0] coord_b;
  logic [LANES-1:0][SUM_BITS-1:0]          lane_pow;
  logic [LANES-1:0]                        lane_done;
  logic [SUM_BITS-1:0]                     new_sum;
  logic                                    over;

  logic                out_valid_q;
  logic [SUM_BITS-1:0] out_sum_q;
  logic                out_abandoned_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= POW_BITS'(1);
      limit_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POWER: power_q <= cfg_data_i[POW_BITS-1:0];
        CFG_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective exponent as a count of extra multiplies
  always_comb begin
    if (power_q == '0) begin
      mul_cnt = '0;
    end else if (power_q inside {[POW_MAX + 1 : (1 << POW_BITS) - 1]}) begin
      mul_cnt = MUL_BITS'(POW_MAX - 1);
    end else begin
      mul_cnt = MUL_BITS'(power_q - 1'b1);
    end
    lanes_clamped = (in_i.lanes_valid > 3'(LANES)) ? LANE_CNT_BITS'(LANES)
                                                   : LANE_CNT_BITS'(in_i.lanes_valid);
  end

  assign coord_a[0] = in_i.coord_a0;
  assign coord_a[1] = in_i.coord_a1;
  assign coord_a[2] = in_i.coord_a2;
  assign coord_a[3] = in_i.coord_a3;
  assign coord_b[0] = in_i.coord_b0;
  assign coord_b[1] = in_i.coord_b1;
  assign coord_b[2] = in_i.coord_b2;
  assign coord_b[3] = in_i.coord_b3;

  // input transfer
  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign start      = accept && !discarding_q;

  always_ff @(posedge clk_i) begin
    if (start) begin
      lanes_q <= lanes_clamped;
      last_q  <= in_i.last_group;
    end
  end

  // lane units
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    lpd_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .start_i   (start),
      .coord_a_i (coord_a[g]),
      .coord_b_i (coord_b[g]),
      .mul_cnt_i (mul_cnt),
      .result_o  (lane_pow[g]),
      .done_o    (lane_done[g])
    );
  end

  lpd_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (merge_ctrl),
    .lane_pow_i (lane_pow),
    .lanes_i    (lanes_q),
    .limit_i    (limit_q),
    .sum_o      (new_sum),
    .over_o     (over)
  );

  assign slot_free = !out_valid_q || out_o.ready;
  assign emit      = over || last_q;

  // sequencer
  always_comb begin
    state_d          = state_q;
    discarding_d     = discarding_q;
    merge_ctrl       = '0;
    out_load         = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (discarding_q) begin
            if (in_i.last_group) begin
              discarding_d     = 1'b0;
              merge_ctrl.clear = 1'b1;
            end
          end else begin
            state_d = S_LANE;
          end
        end
      end
      S_LANE: begin
        if (&lane_done) begin
          merge_ctrl.capture = 1'b1;
          state_d            = S_SUM;
        end
      end
      S_SUM: begin
        if (emit) begin
          if (slot_free) begin
            out_load         = 1'b1;
            merge_ctrl.clear = 1'b1;
            discarding_d     = over && !last_q;
            state_d          = S_IDLE;
          end
        end else begin
          merge_ctrl.load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      discarding_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      discarding_q <= discarding_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sum_q       <= new_sum;
      out_abandoned_q <= over;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.distance_sum = out_sum_q;
  assign out_o.abandoned    = out_abandoned_q;

endmodule

`default_nettype wire

// ----- hdl/lpd_lane.sv -----
`default_nettype none

module lpd_lane (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic signed [lpd_pkg::COORD_BITS-1:0] coord_a_i,
  input  wire logic signed [lpd_pkg::COORD_BITS-1:0] coord_b_i,
  input  wire logic [lpd_pkg::MUL_BITS-1:0]          mul_cnt_i,
  output logic [lpd_pkg::SUM_BITS-1:0]               result_o,
  output logic                                       done_o
);
  import lpd_pkg::*;

  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  logic signed [DIFF_BITS-1:0] diff;
  logic [DIFF_BITS-1:0]        mag;
  logic [DIFF_BITS-1:0]        base_q;
  logic [SUM_BITS-1:0]         r_q;
  logic [SUM_BITS-1:0]         r_d;
  logic [MUL_BITS-1:0]         cnt_q;
  logic                        busy_q;
  logic [PROD_BITS-1:0]        prod;

  // absolute difference of the pair
  always_comb begin
    diff = {coord_a_i[COORD_BITS-1], coord_a_i} - {coord_b_i[COORD_BITS-1], coord_b_i};
    mag  = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
  end

  // one saturating multiply by the base per cycle
  always_comb begin
    prod = PROD_BITS'(r_q) * PROD_BITS'(base_q);
    r_d  = (prod[PROD_BITS-1:SUM_BITS] != '0) ? SUM_MAX : prod[SUM_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= mul_cnt_i;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      base_q <= mag;
      r_q    <= SUM_BITS'(mag);
    end else if (busy_q && cnt_q != '0) begin
      r_q <= r_d;
    end
  end

  assign result_o = r_q;
  assign done_o   = busy_q && (cnt_q == '0);

endmodule

`default_nettype wire

// ----- hdl/lpd_merge.sv -----
`default_nettype none

module lpd_merge (
  input  wire logic                                              clk_i,
  input  wire logic                                              rst_ni,
  input  wire lpd_pkg::merge_ctrl_t                              ctrl_i,
  input  wire logic [lpd_pkg::LANES-1:0][lpd_pkg::SUM_BITS-1:0] lane_pow_i,
  input  wire logic [lpd_pkg::LANE_CNT_BITS-1:0]                 lanes_i,
  input  wire logic [lpd_pkg::SUM_BITS-1:0]                      limit_i,
  output logic [lpd_pkg::SUM_BITS-1:0]                           sum_o,
  output logic                                                   over_o
);
  import lpd_pkg::*;

  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  logic [GRP_BITS-1:0] group_d;
  logic [GRP_BITS-1:0] group_q;
  logic [SUM_BITS-1:0] running_q;
  logic [RUN_BITS-1:0] total;

  // exact sum over the valid lanes
  always_comb begin
    group_d = '0;
    for (int i = 0; i < LANES; i++) begin
      if (LANE_CNT_BITS'(i) < lanes_i) begin
        group_d = group_d + GRP_BITS'(lane_pow_i[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      group_q <= group_d;
    end
  end

  // add into the running sum, clamp, check the limit
  always_comb begin
    total  = RUN_BITS'(running_q) + RUN_BITS'(group_q);
    sum_o  = (total > RUN_BITS'(SUM_MAX)) ? SUM_MAX : total[SUM_BITS-1:0];
    over_o = (limit_i != '0) && (sum_o > limit_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
    end else if (ctrl_i.clear) begin
      running_q <= '0;
    end else if (ctrl_i.load) begin
      running_q <= sum_o;
    end
  end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
module testbench;
  import lpd_pkg::*;

  localparam bit [63:0] SUM_MAX      = (64'd1 << SUM_BITS) - 1;
  localparam int        DRAIN_CYCLES = 12;
  localparam int        CYCLE_LIMIT  = 400000;

  typedef struct {
    bit signed [COORD_BITS-1:0] coord_a [LANES];
    bit signed [COORD_BITS-1:0] coord_b [LANES];
    bit [2:0]                   lanes;
    bit                         last;
  } coord_group_t;

  typedef struct {
    bit [SUM_BITS-1:0] distance_sum;
    bit                abandoned;
  } distance_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [SUM_BITS-1:0]     cfg_data_i;

  lpd_in_if  in_if ();
  lpd_out_if out_if ();

  lp_distance_early_abandon i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // predicted block state and settings
  bit [POW_BITS-1:0] power_reg   = 3'd1;
  bit [SUM_BITS-1:0] limit_reg   = '0;
  bit [63:0]         running_sum = '0;
  bit                discarding  = 1'b0;

  distance_result_t expected_distances[$];
  int unsigned      groups_sent   = 0;
  int unsigned      mismatches    = 0;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  int unsigned      cycle_count   = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run time guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic bit [63:0] saturate_add(input bit [63:0] x, input bit [63:0] y);
    if (x > SUM_MAX - y) return SUM_MAX;
    return x + y;
  endfunction

  function automatic bit [63:0] saturate_mul(input bit [63:0] x, input bit [63:0] y);
    if (x != 0 && y > SUM_MAX / x) return SUM_MAX;
    return x * y;
  endfunction

  // |a - b| raised to p, clamped at the sum maximum
  function automatic bit [63:0] diff_power(input bit signed [COORD_BITS-1:0] a,
                                           input bit signed [COORD_BITS-1:0] b,
                                           input int unsigned p);
    longint    d;
    bit [63:0] base;
    bit [63:0] acc;
    d    = longint'(a) - longint'(b);
    base = (d < 0) ? -d : d;
    if (base > SUM_MAX) base = SUM_MAX;
    acc = base;
    for (int k = 1; k < p; k++) acc = saturate_mul(acc, base);
    return acc;
  endfunction

  // fold one accepted group into the predicted sum
  task automatic accumulate_group(input coord_group_t g);
    int unsigned      p;
    int unsigned      n;
    bit               over;
    distance_result_t res;
    groups_sent++;
    if (discarding) begin
      if (g.last) begin
        discarding  = 1'b0;
        running_sum = '0;
      end
      return;
    end
    p = power_reg;
    if (p == 0) p = 1;
    if (p > POW_MAX) p = POW_MAX;
    n = (g.lanes > LANES) ? LANES : g.lanes;
    for (int i = 0; i < n; i++)
      running_sum = saturate_add(running_sum, diff_power(g.coord_a[i], g.coord_b[i], p));
    over = (limit_reg != 0) && (running_sum > limit_reg);
    if (over || g.last) begin
      res.distance_sum = running_sum[SUM_BITS-1:0];
      res.abandoned    = over;
      expected_distances.push_back(res);
      running_sum = '0;
      discarding  = over && !g.last;
    end
  endtask

  // result side: compare each transfer, then pick the next ready
  always @(posedge clk_i) begin
    distance_result_t exp_res;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_distances.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual sum %h abandoned %b",
                 $time, out_if.distance_sum, out_if.abandoned);
      end else begin
        exp_res = expected_distances.pop_front();
        if (out_if.distance_sum !== exp_res.distance_sum) begin
          mismatches++;
          $display("%0t: distance_sum mismatch: expected %h actual %h",
                   $time, exp_res.distance_sum, out_if.distance_sum);
        end
        if (out_if.abandoned !== exp_res.abandoned) begin
          mismatches++;
          $display("%0t: abandoned mismatch: expected %b actual %b",
                   $time, exp_res.abandoned, out_if.abandoned);
        end
      end
    end
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one group transfer, with a random gap before it; valid stays high afterwards
  task automatic send_group(input coord_group_t g);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid       <= 1'b1;
    in_if.coord_a0    <= g.coord_a[0];
    in_if.coord_a1    <= g.coord_a[1];
    in_if.coord_a2    <= g.coord_a[2];
    in_if.coord_a3    <= g.coord_a[3];
    in_if.coord_b0    <= g.coord_b[0];
    in_if.coord_b1    <= g.coord_b[1];
    in_if.coord_b2    <= g.coord_b[2];
    in_if.coord_b3    <= g.coord_b[3];
    in_if.lanes_valid <= g.lanes;
    in_if.last_group  <= g.last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    accumulate_group(g);
  endtask

  // stop sending and let every pending result and any group in flight finish
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_distances.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register write, only while the block is idle
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [SUM_BITS-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_POWER: power_reg = data[POW_BITS-1:0];
      CFG_LIMIT: limit_reg = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic bit signed [COORD_BITS-1:0] random_coord(input int unsigned style);
    int unsigned s;
    s = (style > 2) ? $urandom_range(2) : style;
    case (s)
      0: return COORD_BITS'($urandom);
      1: return COORD_BITS'(int'($urandom_range(511)) - 256);
      default: begin
        case ($urandom_range(3))
          0: return {1'b1, {(COORD_BITS-1){1'b0}}};
          1: return {1'b0, {(COORD_BITS-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // lane 0 given, the other lanes random
  function automatic coord_group_t build_group(input bit signed [COORD_BITS-1:0] a0,
                                               input bit signed [COORD_BITS-1:0] b0,
                                               input bit [2:0] lanes, input bit last);
    coord_group_t g;
    for (int i = 0; i < LANES; i++) begin
      g.coord_a[i] = random_coord(0);
      g.coord_b[i] = random_coord(0);
    end
    g.coord_a[0] = a0;
    g.coord_b[0] = b0;
    g.lanes      = lanes;
    g.last       = last;
    return g;
  endfunction

  // power 1 and no limit out of reset
  task automatic test_reset_values();
    coord_group_t g;
    g = build_group(16'sh7fff, -16'sh8000, 3'd4, 1'b0);
    send_group(g);
    g = build_group(-16'sh8000, 16'sh7fff, 3'd4, 1'b1);
    g.coord_a[3] = 16'sh7fff;
    g.coord_b[3] = -16'sh8000;
    send_group(g);
    wait_idle();
  endtask

  // every exponent encoding, zero reads as one, above four as four
  task automatic test_power_settings();
    coord_group_t g;
    logic [SUM_BITS-1:0] data;
    write_reg(CFG_LIMIT, '0);
    for (int p = 0; p < 8; p++) begin
      data = {16'($urandom), 32'($urandom)};
      data[POW_BITS-1:0] = POW_BITS'(p);
      write_reg(CFG_POWER, data);
      g = build_group(16'sh7fff, -16'sh8000, 3'd4, 1'b1);
      send_group(g);
      wait_idle();
    end
  endtask

  // zero lanes, partial lanes, and counts clamped to the lane width
  task automatic test_lane_counts();
    bit [2:0] counts [5] = '{3'd0, 3'd3, 3'd4, 3'd5, 3'd7};
    write_reg(CFG_POWER, SUM_BITS'(1));
    foreach (counts[i]) send_group(build_group(random_coord(0), random_coord(0),
                                               counts[i], 1'b1));
    wait_idle();
  endtask

  // abandon mid vector with discard, equal to limit, over on last, saturated sum
  task automatic test_early_abandon();
    write_reg(CFG_POWER, SUM_BITS'(1));
    write_reg(CFG_LIMIT, SUM_BITS'(100));
    send_group(build_group(16'sd50, 16'sd0, 3'd1, 1'b0));
    send_group(build_group(16'sd60, 16'sd0, 3'd1, 1'b0));
    send_group(build_group(16'sd7, 16'sd0, 3'd4, 1'b0));
    send_group(build_group(16'sd9, 16'sd0, 3'd4, 1'b1));
    send_group(build_group(16'sd100, 16'sd0, 3'd1, 1'b1));
    send_group(build_group(-16'sh8000, 16'sh7fff, 3'd2, 1'b1));
    send_group(build_group(16'sd3, 16'sd0, 3'd1, 1'b1));
    wait_idle();
    write_reg(CFG_LIMIT, SUM_MAX[SUM_BITS-1:0]);
    write_reg(CFG_POWER, SUM_BITS'(4));
    send_group(build_group(16'sh7fff, -16'sh8000, 3'd4, 1'b1));
    wait_idle();
  endtask

  // exponent changed between two groups of one vector
  task automatic test_write_mid_vector();
    write_reg(CFG_LIMIT, '0);
    write_reg(CFG_POWER, SUM_BITS'(1));
    send_group(build_group(16'sd3, 16'sd0, 3'd1, 1'b0));
    wait_idle();
    write_reg(CFG_POWER, SUM_BITS'(2));
    send_group(build_group(16'sd5, 16'sd0, 3'd1, 1'b1));
    wait_idle();
  endtask

  // new exponent and limit, each written or kept at random
  task automatic randomize_settings();
    logic [SUM_BITS-1:0] data;
    int unsigned         len;
    wait_idle();
    if ($urandom_range(1)) begin
      data = $urandom_range(1) ? {16'($urandom), 32'($urandom)} : '0;
      data[POW_BITS-1:0] = POW_BITS'($urandom_range(7));
      write_reg(CFG_POWER, data);
    end
    if ($urandom_range(1)) begin
      len  = $urandom_range(1, SUM_BITS);
      data = {16'($urandom), 32'($urandom)} >> (SUM_BITS - len);
      case ($urandom_range(5))
        0: data = '0;
        1: data = SUM_MAX[SUM_BITS-1:0];
        default: ;
      endcase
      write_reg(CFG_LIMIT, data);
    end
  endtask

  task automatic send_random_vector();
    coord_group_t g;
    int unsigned  n_groups;
    int unsigned  style;
    n_groups = $urandom_range(1, 6);
    style    = $urandom_range(3);
    for (int k = 0; k < n_groups; k++) begin
      for (int i = 0; i < LANES; i++) begin
        g.coord_a[i] = random_coord(style);
        g.coord_b[i] = random_coord(style);
      end
      if ($urandom_range(9) == 0)
        g.lanes = $urandom_range(1) ? 3'd0 : 3'($urandom_range(5, 7));
      else
        g.lanes = 3'($urandom_range(1, LANES));
      g.last = (k == n_groups - 1);
      send_group(g);
    end
  endtask

  // random vectors under one idle pattern
  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                     input int unsigned n_groups);
    int unsigned target;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    target = groups_sent + n_groups;
    while (groups_sent < target) begin
      if ($urandom_range(7) == 0) randomize_settings();
      send_random_vector();
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_POWER;
    cfg_data_i        = '0;
    in_if.valid       = 1'b0;
    in_if.coord_a0    = '0;
    in_if.coord_a1    = '0;
    in_if.coord_a2    = '0;
    in_if.coord_a3    = '0;
    in_if.coord_b0    = '0;
    in_if.coord_b1    = '0;
    in_if.coord_b2    = '0;
    in_if.coord_b3    = '0;
    in_if.lanes_valid = '0;
    in_if.last_group  = 1'b0;
    out_if.ready      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 17;
    recv_idle_pct = 65;
    test_reset_values();
    test_power_settings();
    test_lane_counts();
    test_early_abandon();
    test_write_mid_vector();

    test_random_traffic(17, 65, 285);
    test_random_traffic(65, 17, 285);
    test_random_traffic(0, 0, 280);

    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
